FILE: hdl/dzv_pkg.sv
// ----------------------------------------------------------------------------
// dzv_pkg - shared types and constants
// Payload structs, front-to-back token format, status codes and the
// register map of the zigzag delta varint decoder.
// ----------------------------------------------------------------------------
package dzv_pkg;

   localparam int MAX_GROUP_BYTES_DEFAULT = 10;
   localparam int QUEUE_DEPTH_DEFAULT     = 4;

   localparam logic [7:0] GROUP_MASK = 8'h7F;
   localparam int         CONT_BIT   = 7;
   localparam int         GROUP_BITS = 7;
   localparam int         VALUE_W    = 64;
   localparam int         COUNT_W    = 32;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_TOO_LONG = 3'd1;
   localparam logic [2:0] ST_CUT_OFF  = 3'd2;
   localparam logic [2:0] ST_SHORT    = 3'd3;
   localparam logic [2:0] ST_NEGATIVE = 3'd4;

   localparam int                    CSR_ADDR_W       = 2;
   localparam int                    CSR_DATA_W       = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_VALUE_COUNT = 2'd0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic [2:0]         status;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      TOK_VALUE,
      TOK_ERROR,
      TOK_END
   } token_kind_type;

   typedef struct packed {
      token_kind_type     kind;
      logic [2:0]         status;
      logic               first;
      logic               count_hit;
      logic               end_flag;
      logic [VALUE_W-1:0] acc;
   } token_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hdl/delta_zigzag_varint_decoder_top.sv
// ----------------------------------------------------------------------------
// delta_zigzag_varint_decoder_top - zigzag delta varint decoder
// Decodes a little-endian 7-bit varint byte stream into absolute values.
//
//   channel | direction | handshake            | payload
//   req_    | in        | push / full          | data_byte, end_of_data
//   rsp_    | out       | pop / empty          | value, last, status
//   csr_    | in/out    | psel penable pwrite  | value_count at address 0
//
// One byte per clock sustained while req_full is low; a finished value's token
// is written into the token queue, and the back then takes it from there into
// the result register once that register is free or being popped.
// The token queue decouples intake from the delta adder and result register;
// full rises only when the queue is full while results are not popped.
// Reset is synchronous and clears count, control state and queue at once.
// ----------------------------------------------------------------------------
module delta_zigzag_varint_decoder_top #(
   parameter int MAX_GROUP_BYTES = dzv_pkg::MAX_GROUP_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH     = dzv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  dzv_pkg::req_payload_type       req_payload,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output dzv_pkg::rsp_payload_type       rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dzv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dzv_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dzv_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import dzv_pkg::*;

   logic [COUNT_W-1:0] value_count_ff, value_count_in;
   logic               csr_write;
   logic               accept;
   logic               tok_write;
   token_type          tok_front;
   token_type          tok_back;
   logic               tok_take;
   queue_status_type   q_status;

   always_comb begin
      csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == ADDR_VALUE_COUNT);
      value_count_in = csr_write ? csr_pwdata : value_count_ff;
      csr_prdata     = (csr_paddr == ADDR_VALUE_COUNT) ? value_count_ff : '0;
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_count_ff <= '0;
      end else begin
         value_count_ff <= value_count_in;
      end
   end

   assign req_full = q_status.full;
   assign accept   = req_push && !req_full;

   dzv_front #(
      .MAX_GROUP_BYTES(MAX_GROUP_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .value_count(value_count_ff),
      .accept     (accept),
      .payload    (req_payload),
      .tok_write  (tok_write),
      .tok        (tok_front)
   );

   dzv_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (tok_write),
      .wr_data(tok_front),
      .rd_en  (tok_take),
      .rd_data(tok_back),
      .status (q_status)
   );

   dzv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (!q_status.empty),
      .tok        (tok_back),
      .tok_take   (tok_take),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_payload(rsp_payload)
   );

`ifndef SYNTHESIS
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_payload.status == ST_OK || rsp_payload.last))
      else $error("error result without last");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.status != ST_OK) |-> (rsp_payload.value == '0))
      else $error("error result with nonzero value");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result present right after reset");

   a_no_token_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !tok_write)
      else $error("token written into full queue");
`endif

endmodule

FILE: hdl/dzv_queue.sv
// ----------------------------------------------------------------------------
// dzv_queue - token queue between front and back
// Small register queue; write and read in the same cycle are allowed.
// ----------------------------------------------------------------------------
module dzv_queue #(
   parameter int DEPTH = dzv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  dzv_pkg::token_type        wr_data,
   input  logic                      rd_en,
   output dzv_pkg::token_type        rd_data,
   output dzv_pkg::queue_status_type status
);
   import dzv_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

FILE: hdl/dzv_front.sv
// ----------------------------------------------------------------------------
// dzv_front - byte intake and group assembly
// Assembles 7-bit groups, counts values, flags length and cut-off errors
// and hands one token per finished group, error or buffer end to the back.
// ----------------------------------------------------------------------------
module dzv_front #(
   parameter int MAX_GROUP_BYTES = dzv_pkg::MAX_GROUP_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [dzv_pkg::COUNT_W-1:0]  value_count,
   input  logic                         accept,
   input  dzv_pkg::req_payload_type     payload,
   output logic                         tok_write,
   output dzv_pkg::token_type           tok
);
   import dzv_pkg::*;

   localparam int IDX_W = $clog2(MAX_GROUP_BYTES);

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0] done_ff, done_in;
   logic               halted_ff, halted_in;

   logic               active;
   logic               cont;
   logic [6:0]         shift;
   logic [VALUE_W-1:0] acc_new;
   logic [IDX_W:0]     next_idx;
   logic               too_long;

   always_comb begin
      active   = !halted_ff && (done_ff < value_count);
      cont     = payload.data_byte[CONT_BIT];
      shift    = 7'(idx_ff) * 7'(GROUP_BITS);
      acc_new  = acc_ff | (VALUE_W'(payload.data_byte & GROUP_MASK) << shift);
      next_idx = {1'b0, idx_ff} + 1'b1;
      too_long = (next_idx >= (IDX_W + 1)'(MAX_GROUP_BYTES));
   end

   always_comb begin
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      done_in       = done_ff;
      halted_in     = halted_ff;
      tok_write     = 1'b0;
      tok.kind      = TOK_END;
      tok.status    = ST_OK;
      tok.first     = (done_ff == '0);
      tok.count_hit = (COUNT_W'(done_ff + 1'b1) == value_count);
      tok.end_flag  = payload.end_of_data;
      tok.acc       = acc_new;
      if (accept) begin
         if (active) begin
            if (cont) begin
               if (too_long) begin
                  tok_write  = 1'b1;
                  tok.kind   = TOK_ERROR;
                  tok.status = ST_TOO_LONG;
                  halted_in  = 1'b1;
               end else if (payload.end_of_data) begin
                  tok_write  = 1'b1;
                  tok.kind   = TOK_ERROR;
                  tok.status = ST_CUT_OFF;
                  halted_in  = 1'b1;
               end else begin
                  idx_in = next_idx[IDX_W-1:0];
                  acc_in = acc_new;
               end
            end else begin
               tok_write = 1'b1;
               tok.kind  = TOK_VALUE;
               done_in   = done_ff + 1'b1;
               acc_in    = '0;
               idx_in    = '0;
            end
         end else if (payload.end_of_data) begin
            tok_write = 1'b1;
         end
         if (payload.end_of_data) begin
            acc_in    = '0;
            idx_in    = '0;
            done_in   = '0;
            halted_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         idx_ff    <= '0;
         done_ff   <= '0;
         halted_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         idx_ff    <= idx_in;
         done_ff   <= done_in;
         halted_ff <= halted_in;
      end
   end

endmodule

FILE: hdl/dzv_back.sv
// ----------------------------------------------------------------------------
// dzv_back - delta accumulation and result register
// Applies zigzag deltas to the running value, checks sign and count,
// and holds one result for the output side.
// ----------------------------------------------------------------------------
module dzv_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tok_valid,
   input  dzv_pkg::token_type       tok,
   output logic                     tok_take,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output dzv_pkg::rsp_payload_type rsp_payload
);
   import dzv_pkg::*;

   logic [VALUE_W-1:0] running_ff, running_in;
   logic               halted_ff, halted_in;
   logic               out_valid_ff, out_valid_in;
   rsp_payload_type    out_ff, out_in;

   logic [VALUE_W-1:0] delta;
   logic [VALUE_W-1:0] sum;
   logic [VALUE_W-1:0] new_running;
   logic               neg;
   logic               emit;
   logic               halt;

   always_comb begin
      tok_take    = tok_valid && (!out_valid_ff || rsp_pop);
      delta       = {1'b0, tok.acc[VALUE_W-1:1]} ^ {VALUE_W{tok.acc[0]}};
      sum         = running_ff + delta;
      new_running = tok.first ? tok.acc : sum;
      neg         = !tok.first && sum[VALUE_W-1];
   end

   always_comb begin
      emit       = 1'b0;
      halt       = 1'b0;
      running_in = running_ff;
      out_in     = out_ff;
      if (tok_take && !halted_ff) begin
         case (tok.kind)
            TOK_VALUE: begin
               emit       = 1'b1;
               running_in = new_running;
               if (neg) begin
                  out_in = '{value: '0, last: 1'b1, status: ST_NEGATIVE};
                  halt   = 1'b1;
               end else if (tok.count_hit) begin
                  out_in = '{value: new_running, last: 1'b1, status: ST_OK};
               end else if (tok.end_flag) begin
                  out_in = '{value: '0, last: 1'b1, status: ST_SHORT};
                  halt   = 1'b1;
               end else begin
                  out_in = '{value: new_running, last: 1'b0, status: ST_OK};
               end
            end
            TOK_ERROR: begin
               emit   = 1'b1;
               halt   = 1'b1;
               out_in = '{value: '0, last: 1'b1, status: tok.status};
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
      halted_in = halted_ff;
      if (tok_take) begin
         halted_in = tok.end_flag ? 1'b0 : (halted_ff || halt);
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         halted_ff    <= halted_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      running_ff <= running_in;
      out_ff     <= out_in;
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
